// ----- rtl/cslx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cslx_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // strip state codes
  localparam logic [2:0] SM_NORMAL     = 3'd0;
  localparam logic [2:0] SM_SLASH      = 3'd1;
  localparam logic [2:0] SM_LINE       = 3'd2;
  localparam logic [2:0] SM_BLOCK      = 3'd3;
  localparam logic [2:0] SM_BLOCK_STAR = 3'd4;

  // open lexeme codes
  localparam logic [1:0] LM_NONE   = 2'd0;
  localparam logic [1:0] LM_IDENT  = 2'd1;
  localparam logic [1:0] LM_NUMBER = 2'd2;
  localparam logic [1:0] LM_QUOTED = 2'd3;

  // lexeme kind codes on the result channel
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_QUOTED = 3'd2;
  localparam logic [2:0] KIND_PUNCT  = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [2:0] lexeme_kind;
    logic       starts_lexeme;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] lmode;
    logic       quote_single;
  } lex_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       start;
    lex_state_t nxt;
  } tag_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || (b inside {[8'd9:8'd13]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'd48:8'd57]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'd65:8'd90], [8'd97:8'd122]};
  endfunction

  // Classify one kept byte against the open lexeme.
  function automatic tag_t tag_byte(input lex_state_t s, input logic [7:0] b);
    tag_t       t;
    logic [7:0] close_q;
    t.kind  = KIND_OTHER;
    t.start = 1'b0;
    t.nxt   = s;
    close_q = s.quote_single ? CH_SQUOTE : CH_DQUOTE;
    if (s.lmode == LM_QUOTED) begin
      t.kind = KIND_QUOTED;
      if (b == close_q) t.nxt.lmode = LM_NONE;
    end else if (s.lmode == LM_IDENT && (is_alpha(b) || is_digit(b) || b == CH_UNDER)) begin
      t.kind = KIND_IDENT;
    end else if (s.lmode == LM_NUMBER && is_digit(b)) begin
      t.kind = KIND_NUMBER;
    end else if (is_alpha(b) || b == CH_UNDER) begin
      t.kind      = KIND_IDENT;
      t.start     = 1'b1;
      t.nxt.lmode = LM_IDENT;
    end else if (is_digit(b)) begin
      t.kind      = KIND_NUMBER;
      t.start     = 1'b1;
      t.nxt.lmode = LM_NUMBER;
    end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      t.kind             = KIND_QUOTED;
      t.start            = 1'b1;
      t.nxt.lmode        = LM_QUOTED;
      t.nxt.quote_single = (b == CH_SQUOTE);
    end else if (b inside {[8'd33:8'd126]}) begin
      t.kind      = KIND_PUNCT;
      t.start     = 1'b1;
      t.nxt.lmode = LM_NONE;
    end else begin
      t.kind      = KIND_OTHER;
      t.nxt.lmode = LM_NONE;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cslx_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One byte of comment stripping and lexeme tagging: up to two results.
module cslx_step import cslx_pkg::*; (
  input  wire logic [2:0] strip_mode,
  input  wire lex_state_t lex_state,
  input  wire in_item_t   item,
  output logic [2:0]      strip_mode_nxt,
  output lex_state_t      lex_state_nxt,
  output logic [1:0]      n_res,
  output out_item_t       res0,
  output out_item_t       res1
);

  tag_t       tag_sl;
  tag_t       tag_b0;
  tag_t       tag_b1;
  logic [7:0] b;

  assign b      = item.in_byte;
  assign tag_sl = tag_byte(lex_state, CH_SLASH);
  assign tag_b0 = tag_byte(lex_state, b);
  assign tag_b1 = tag_byte(tag_sl.nxt, b);

  always_comb begin
    strip_mode_nxt = strip_mode;
    lex_state_nxt  = lex_state;
    n_res          = 2'd0;
    res0           = '{out_char: CH_SLASH, lexeme_kind: tag_sl.kind,
                       starts_lexeme: tag_sl.start, last: 1'b1};
    res1           = '{out_char: b, lexeme_kind: tag_b1.kind,
                       starts_lexeme: tag_b1.start, last: 1'b1};
    if (item.end_of_input) begin
      n_res          = (strip_mode == SM_SLASH) ? 2'd1 : 2'd0;
      strip_mode_nxt = SM_NORMAL;
      lex_state_nxt  = '{lmode: LM_NONE, quote_single: 1'b0};
    end else begin
      case (strip_mode)
        SM_SLASH: begin
          if (b == CH_SLASH) begin
            strip_mode_nxt = SM_LINE;
          end else if (b == CH_STAR) begin
            strip_mode_nxt = SM_BLOCK;
          end else begin
            // held slash was an operator; emit it, then this byte as normal
            n_res          = 2'd1;
            lex_state_nxt  = tag_sl.nxt;
            strip_mode_nxt = SM_NORMAL;
            if (!is_space(b)) begin
              n_res         = 2'd2;
              res0.last     = 1'b0;
              lex_state_nxt = tag_b1.nxt;
            end
          end
        end
        SM_LINE: begin
          if (b == CH_NL) strip_mode_nxt = SM_NORMAL;
        end
        SM_BLOCK: begin
          if (b == CH_STAR) strip_mode_nxt = SM_BLOCK_STAR;
        end
        SM_BLOCK_STAR: begin
          if (b == CH_SLASH) strip_mode_nxt = SM_NORMAL;
          else if (b != CH_STAR) strip_mode_nxt = SM_BLOCK;
        end
        default: begin
          strip_mode_nxt = SM_NORMAL;
          if (b == CH_SLASH) begin
            strip_mode_nxt = SM_SLASH;
          end else if (!is_space(b)) begin
            n_res         = 2'd1;
            lex_state_nxt = tag_b0.nxt;
            res0          = '{out_char: b, lexeme_kind: tag_b0.kind,
                              starts_lexeme: tag_b0.start, last: 1'b1};
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/comment_strip_lexeme_splitter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Strips // and /* */ comments and whitespace from a byte stream and tags each
// kept byte with its lexeme kind and a start-of-lexeme flag. One input item is
// taken per cycle while in_ready is high; its results are written into a
// four-entry result queue. An item yields zero, one or two results (two when a
// held slash turns out not to open a comment). A two-result item always follows
// a slash that yielded nothing, so with out_ready held high the queue never
// holds more than two results and the input takes one item every cycle.
// in_ready is high whenever the queue has room for two results; a stalled
// receiver fills the queue and then holds the input off.
module comment_strip_lexeme_splitter_top import cslx_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [2:0] sm_r;
  lex_state_t lx_r;
  logic [2:0] sm_nxt;
  lex_state_t lx_nxt;
  logic [1:0] n_res;
  out_item_t  res0;
  out_item_t  res1;

  out_item_t  q_r [4];
  logic [1:0] wp_r;
  logic [1:0] rp_r;
  logic [2:0] cnt_r;
  logic [1:0] wp_nxt;
  logic [1:0] rp_nxt;
  logic [2:0] cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  cslx_step u_step (
    .strip_mode     (sm_r),
    .lex_state      (lx_r),
    .item           (in_data),
    .strip_mode_nxt (sm_nxt),
    .lex_state_nxt  (lx_nxt),
    .n_res          (n_res),
    .res0           (res0),
    .res1           (res1)
  );

  assign in_ready  = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rp_r];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      wp_nxt  = wp_r + n_res;
      cnt_nxt = cnt_nxt + {1'b0, n_res};
    end
    if (out_acc) begin
      rp_nxt  = rp_r + 2'd1;
      cnt_nxt = cnt_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_r  <= SM_NORMAL;
      lx_r  <= '{lmode: LM_NONE, quote_single: 1'b0};
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (in_acc) begin
        sm_r <= sm_nxt;
        lx_r <= lx_nxt;
      end
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) q_r[wp_r] <= res0;
    if (in_acc && n_res == 2'd2) q_r[wp_r + 2'd1] <= res1;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue overflow");

  a_eoi_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.end_of_input |=> sm_r == SM_NORMAL && lx_r.lmode == LM_NONE)
    else $error("end of input did not reset state");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !in_acc |=> cnt_r == $past(cnt_r) - 3'd1)
    else $error("queue count wrong after drain");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 || cnt_r == 3'd4) |-> wp_r == rp_r)
    else $error("queue pointers out of step");

endmodule

`default_nettype wire

// ----- tb/sv/comment_strip_lexeme_splitter_top_test.sv -----
`timescale 1ns / 1ps

module comment_strip_lexeme_splitter_top_test;
  import cslx_pkg::*;

  class lexeme_scoreboard;
    logic [2:0] strip_st;
    logic [1:0] lex_st;
    logic       quote_sq;
    out_item_t  tagged_due[$];
    int         errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      strip_st = SM_NORMAL;
      lex_st   = LM_NONE;
      quote_sq = 1'b0;
    endfunction

    function bit blank(logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function bit numeral(logic [7:0] b);
      return b >= 8'd48 && b <= 8'd57;
    endfunction

    function bit letter(logic [7:0] b);
      return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
    endfunction

    // Tag one kept byte against the open lexeme and queue it.
    function void tag_kept(logic [7:0] b);
      out_item_t r;
      r.out_char      = b;
      r.lexeme_kind   = KIND_OTHER;
      r.starts_lexeme = 1'b0;
      r.last          = 1'b0;
      if (lex_st == LM_QUOTED) begin
        r.lexeme_kind = KIND_QUOTED;
        if (b == (quote_sq ? CH_SQUOTE : CH_DQUOTE)) lex_st = LM_NONE;
      end else if (lex_st == LM_IDENT && (letter(b) || numeral(b) || b == CH_UNDER)) begin
        r.lexeme_kind = KIND_IDENT;
      end else if (lex_st == LM_NUMBER && numeral(b)) begin
        r.lexeme_kind = KIND_NUMBER;
      end else if (letter(b) || b == CH_UNDER) begin
        r.lexeme_kind   = KIND_IDENT;
        r.starts_lexeme = 1'b1;
        lex_st          = LM_IDENT;
      end else if (numeral(b)) begin
        r.lexeme_kind   = KIND_NUMBER;
        r.starts_lexeme = 1'b1;
        lex_st          = LM_NUMBER;
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        r.lexeme_kind   = KIND_QUOTED;
        r.starts_lexeme = 1'b1;
        lex_st          = LM_QUOTED;
        quote_sq        = (b == CH_SQUOTE);
      end else if (b >= 8'd33 && b <= 8'd126) begin
        r.lexeme_kind   = KIND_PUNCT;
        r.starts_lexeme = 1'b1;
        lex_st          = LM_NONE;
      end else begin
        lex_st = LM_NONE;
      end
      tagged_due.push_back(r);
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == CH_SLASH) strip_st = SM_SLASH;
      else if (!blank(b)) tag_kept(b);
    endfunction

    function void take_source_item(in_item_t it);
      int        due_prior;
      out_item_t tail;
      due_prior = tagged_due.size();
      if (it.end_of_input) begin
        if (strip_st == SM_SLASH) tag_kept(CH_SLASH);
        clear_state();
      end else begin
        case (strip_st)
          SM_SLASH: begin
            if (it.in_byte == CH_SLASH) strip_st = SM_LINE;
            else if (it.in_byte == CH_STAR) strip_st = SM_BLOCK;
            else begin
              // held slash was not a comment opener
              strip_st = SM_NORMAL;
              tag_kept(CH_SLASH);
              plain_byte(it.in_byte);
            end
          end
          SM_LINE: begin
            if (it.in_byte == CH_NL) strip_st = SM_NORMAL;
          end
          SM_BLOCK: begin
            if (it.in_byte == CH_STAR) strip_st = SM_BLOCK_STAR;
          end
          SM_BLOCK_STAR: begin
            if (it.in_byte == CH_SLASH) strip_st = SM_NORMAL;
            else if (it.in_byte != CH_STAR) strip_st = SM_BLOCK;
          end
          default: begin
            strip_st = SM_NORMAL;
            plain_byte(it.in_byte);
          end
        endcase
      end
      if (tagged_due.size() > due_prior) begin
        tail      = tagged_due.pop_back();
        tail.last = 1'b1;
        tagged_due.push_back(tail);
      end
    endfunction

    function void flag(string what, int exp, int act);
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp, act);
    endfunction

    function void check_tagged_byte(out_item_t got);
      out_item_t want;
      if (tagged_due.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result: expected none, actual char %0d kind %0d",
                   $time, got.out_char, got.lexeme_kind);
        return;
      end
      want = tagged_due.pop_front();
      if (got.out_char !== want.out_char) flag("out_char", want.out_char, got.out_char);
      if (got.lexeme_kind !== want.lexeme_kind)
        flag("lexeme_kind", want.lexeme_kind, got.lexeme_kind);
      if (got.starts_lexeme !== want.starts_lexeme)
        flag("starts_lexeme", want.starts_lexeme, got.starts_lexeme);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  lexeme_scoreboard board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int live_items = 0;

  comment_strip_lexeme_splitter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: check accepted items, then pick out_ready for the next edge
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) board.check_tagged_byte(out_data);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi, input bit live);
    in_item_t it;
    it.in_byte      = b;
    it.end_of_input = eoi;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    board.take_source_item(it);
    if (live) live_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'd65 + 8'(r);
    if (r < 52) return 8'd97 + 8'(r - 26);
    if (r == 52) return CH_UNDER;
    return 8'd48 + 8'(r - 53);
  endfunction

  // One random piece of C-like source.
  task automatic send_fragment();
    string      puncts;
    int         n;
    logic [7:0] q;
    puncts = "!#$%&()*+,-.:;<=>?@[\\]^`{|}~";
    n = $urandom_range(0, 5);
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 14: begin
        send_item(word_char(1'b1), 1'b0, 1'b1);
        repeat (n) send_item(word_char(1'b0), 1'b0, 1'b1);
      end
      4, 5: repeat (n + 1) send_item(8'd48 + 8'($urandom_range(0, 9)), 1'b0, 1'b1);
      6, 15: begin
        // whitespace: tab through carriage return, or space
        q = 8'($urandom_range(0, 5));
        send_item((q == 8'd5) ? 8'd32 : 8'd9 + q, 1'b0, 1'b1);
      end
      7: send_item(puncts[$urandom_range(0, puncts.len() - 1)], 1'b0, 1'b1);
      8: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        send_item(q, 1'b0, 1'b1);
        repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        if ($urandom_range(0, 99) < 80) send_item(q, 1'b0, 1'b1);
      end
      9: begin
        send_item(CH_SLASH, 1'b0, 1'b1);
        send_item(CH_SLASH, 1'b0, 1'b1);
        repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(CH_NL, 1'b0, 1'b0);
      end
      10: begin
        send_item(CH_SLASH, 1'b0, 1'b1);
        send_item(CH_STAR, 1'b0, 1'b1);
        repeat (n)
          send_item($urandom_range(0, 2) == 0 ? CH_STAR : 8'($urandom_range(0, 255)),
                    1'b0, 1'b0);
        repeat ($urandom_range(1, 3)) send_item(CH_STAR, 1'b0, 1'b0);
        send_item(CH_SLASH, 1'b0, 1'b0);
      end
      11: begin
        send_item(CH_SLASH, 1'b0, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      12: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      default: begin
        if ($urandom_range(0, 1)) send_item(CH_SLASH, 1'b0, 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
    endcase
  endtask

  initial begin
    int target;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lexeme kinds, comments, stray slash, end of input
    send_text("a_9 12/x");
    send_text("//\n");
    send_text("/**/");
    send_text("'\"'");
    send_item(8'hff, 1'b0, 1'b1);
    send_item(CH_SLASH, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_text("!");
    send_text("\"q");
    send_item(8'h00, 1'b1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 300;  // fill the result queue, back-pressure the input
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 31;
          recv_stall_pct = 31;
        end
      endcase
      target = live_items + 425;
      while (live_items < target) send_fragment();
    end

    in_valid <= 1'b0;
    while (board.tagged_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.tagged_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
